// ===== rtl/core/ffba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

  localparam int unsigned BlockBytesDef = 128;
  localparam int unsigned HeapBytesDef  = 131072;

  localparam int unsigned OpW    = 2;
  localparam int unsigned ReqW   = 18;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned BlkCntW = 11;
  localparam int unsigned RegCntW = 10;

  localparam logic [OpW-1:0] OP_ALLOC = 2'd0;
  localparam logic [OpW-1:0] OP_FREE  = 2'd1;
  localparam logic [OpW-1:0] OP_STATS = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_FIND = 6'b000010,
    S_MARK = 6'b000100,
    S_FREE = 6'b001000,
    S_STAT = 6'b010000,
    S_DONE = 6'b100000
  } state_e;

endpackage
`default_nettype wire

// ===== rtl/core/ffba_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ffba_cell #(
  parameter int unsigned LenW = 11
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire logic            used_i,
  input  wire logic [LenW-1:0] len_i,
  output logic                 used_o,
  output logic [LenW-1:0]      len_o
);

  logic            used_q;
  logic [LenW-1:0] len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      len_q  <= '0;
    end else if (shift_i) begin
      used_q <= used_i;
      len_q  <= len_i;
    end
  end

  assign used_o = used_q;
  assign len_o  = len_q;

endmodule
`default_nettype wire

// ===== rtl/core/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An allocation searches the N = HEAP_BYTES/BLOCK_BYTES blocks in one pass and marks a found
// run in a second; free and statistics take one pass; zero-byte, oversized, out-of-heap and
// unknown ones none. One at a time; each pass rotates the ring once through the head cell.
// Reset: asynchronous, active low; every block free, heap_base 0, no result pending.
// BLOCK_BYTES and HEAP_BYTES are powers of two.
module first_fit_block_allocator #(
  parameter int unsigned BLOCK_BYTES = ffba_pkg::BlockBytesDef,
  parameter int unsigned HEAP_BYTES  = ffba_pkg::HeapBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [31:0] cfg_heap_base_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [17:0] request_bytes_i,
  input  wire logic [31:0] release_address_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             status_o,
  output logic [31:0]      alloc_address_o,
  output logic [10:0]      free_block_total_o,
  output logic [10:0]      used_block_total_o,
  output logic [9:0]       free_region_total_o,
  output logic [9:0]       used_region_total_o
);

  localparam int unsigned Total = HEAP_BYTES / BLOCK_BYTES;
  localparam int unsigned Sh    = $clog2(BLOCK_BYTES);
  localparam int unsigned IdxW  = $clog2(Total);
  localparam int unsigned CntW  = $clog2(Total + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Total - 1);

  ffba_pkg::state_e state_q, state_d;

  logic [31:0]     base_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CntW-1:0] need_q, need_d;
  logic [CntW-1:0] run_q, run_d;
  logic [CntW-1:0] start_q, start_d;
  logic            found_q, found_d;
  logic [IdxW-1:0] target_q, target_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            prev_q, prev_d;
  logic [CntW-1:0] fb_q, fb_d, ub_q, ub_d, fr_q, fr_d, ur_q, ur_d;
  logic            rstat_q, rstat_d;
  logic [31:0]     raddr_q, raddr_d;

  logic            out_valid_q;
  logic            ostat_q;
  logic [31:0]     oaddr_q;
  logic [10:0]     ofb_q, oub_q;
  logic [9:0]      ofr_q, our_q;

  logic                used_w [Total+1];
  logic [CntW-1:0]     len_w  [Total+1];
  logic                shift;
  logic                head_used, head_used_n;
  logic [CntW-1:0]     head_len, head_len_n;

  logic [31:0] bytes_rnd, need_full;
  logic [32:0] off;
  logic [32:0] fidx;
  logic        free_ok;
  logic [CntW-1:0] idx_c, end_c;
  logic [31:0] fb32, ub32, fr32, ur32;
  logic        in_acc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ffba_pkg::S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign shift       = (state_q == ffba_pkg::S_FIND) || (state_q == ffba_pkg::S_MARK) ||
                       (state_q == ffba_pkg::S_FREE) || (state_q == ffba_pkg::S_STAT);

  for (genvar g = 0; g < Total; g++) begin : g_ring
    ffba_cell #(.LenW(CntW)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .used_i  (used_w[g+1]),
      .len_i   (len_w[g+1]),
      .used_o  (used_w[g]),
      .len_o   (len_w[g])
    );
  end
  assign head_used    = used_w[0];
  assign head_len     = len_w[0];
  assign used_w[Total] = head_used_n;
  assign len_w[Total]  = head_len_n;

  assign bytes_rnd = 32'(request_bytes_i) + 32'(BLOCK_BYTES - 1);
  assign need_full = bytes_rnd >> Sh;
  assign off       = {1'b0, release_address_i} - {1'b0, base_q};
  assign fidx      = off >> Sh;
  assign free_ok   = (release_address_i != 32'd0) && (release_address_i >= base_q) &&
                     (off < 33'(HEAP_BYTES)) && (fidx < 33'(Total));
  assign idx_c     = CntW'(idx_q);
  assign end_c     = start_q + need_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      base_q <= cfg_heap_base_i;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    need_d      = need_q;
    run_d       = run_q;
    start_d     = start_q;
    found_d     = found_q;
    target_d    = target_q;
    rem_d       = rem_q;
    prev_d      = prev_q;
    fb_d        = fb_q;
    ub_d        = ub_q;
    fr_d        = fr_q;
    ur_d        = ur_q;
    rstat_d     = rstat_q;
    raddr_d     = raddr_q;
    head_used_n = head_used;
    head_len_n  = head_len;
    unique case (state_q)
      ffba_pkg::S_IDLE: begin
        if (in_acc) begin
          idx_d   = '0;
          run_d   = '0;
          start_d = '0;
          found_d = 1'b0;
          rem_d   = '0;
          prev_d  = 1'b0;
          fb_d    = '0;
          ub_d    = '0;
          fr_d    = '0;
          ur_d    = '0;
          rstat_d = 1'b1;
          raddr_d = '0;
          need_d  = CntW'(need_full);
          state_d = ffba_pkg::S_DONE;
          if (operation_i == ffba_pkg::OP_ALLOC) begin
            if (need_full == 32'd0) begin
              raddr_d = base_q;
            end else if (need_full > 32'(Total)) begin
              rstat_d = 1'b0;
            end else begin
              state_d = ffba_pkg::S_FIND;
            end
          end else if (operation_i == ffba_pkg::OP_FREE) begin
            target_d = IdxW'(fidx);
            if (free_ok) state_d = ffba_pkg::S_FREE;
          end else if (operation_i == ffba_pkg::OP_STATS) begin
            state_d = ffba_pkg::S_STAT;
          end
        end
      end
      ffba_pkg::S_FIND: begin
        if (!found_q) begin
          if (head_used) begin
            run_d   = '0;
            start_d = idx_c + 1'b1;
          end else begin
            run_d = run_q + 1'b1;
            if (run_q + 1'b1 == need_q) found_d = 1'b1;
          end
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          idx_d = '0;
          if (found_d) begin
            state_d = ffba_pkg::S_MARK;
          end else begin
            rstat_d = 1'b0;
            state_d = ffba_pkg::S_DONE;
          end
        end
      end
      ffba_pkg::S_MARK: begin
        if (idx_c >= start_q && idx_c < end_c) begin
          head_used_n = 1'b1;
          head_len_n  = (idx_c == start_q) ? need_q : '0;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          raddr_d = base_q + (32'(start_q) << Sh);
          state_d = ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_FREE: begin
        if (idx_q == target_q) begin
          if (head_len != '0) begin
            head_used_n = 1'b0;
            head_len_n  = '0;
            rem_d       = head_len - 1'b1;
          end
        end else if (rem_q != '0) begin
          head_used_n = 1'b0;
          head_len_n  = '0;
          rem_d       = rem_q - 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_STAT: begin
        if (head_used) begin
          ub_d = ub_q + 1'b1;
          if (idx_q == '0 || !prev_q) ur_d = ur_q + 1'b1;
        end else begin
          fb_d = fb_q + 1'b1;
          if (idx_q == '0 || prev_q) fr_d = fr_q + 1'b1;
        end
        prev_d = head_used;
        idx_d  = idx_q + 1'b1;
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ffba_pkg::S_IDLE;
      end
      default: state_d = ffba_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ffba_pkg::S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    need_q   <= need_d;
    run_q    <= run_d;
    start_q  <= start_d;
    found_q  <= found_d;
    target_q <= target_d;
    rem_q    <= rem_d;
    prev_q   <= prev_d;
    fb_q     <= fb_d;
    ub_q     <= ub_d;
    fr_q     <= fr_d;
    ur_q     <= ur_d;
    rstat_q  <= rstat_d;
    raddr_q  <= raddr_d;
  end

  assign fb32 = 32'(fb_q);
  assign ub32 = 32'(ub_q);
  assign fr32 = 32'(fr_q);
  assign ur32 = 32'(ur_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ffba_pkg::S_DONE && (!out_valid_q || out_ready_i)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ffba_pkg::S_DONE && (!out_valid_q || out_ready_i)) begin
      ostat_q <= rstat_q;
      oaddr_q <= raddr_q;
      ofb_q   <= fb32[10:0];
      oub_q   <= ub32[10:0];
      ofr_q   <= fr32[9:0];
      our_q   <= ur32[9:0];
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = ostat_q;
  assign alloc_address_o     = oaddr_q;
  assign free_block_total_o  = ofb_q;
  assign used_block_total_o  = oub_q;
  assign free_region_total_o = ofr_q;
  assign used_region_total_o = our_q;

`ifndef SYNTH
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ffba_pkg::S_DONE))
    else $error("result raised outside done");
  a_mark_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ffba_pkg::S_MARK |-> found_q)
    else $error("mark pass without a run");
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ffba_pkg::S_FIND |-> run_q <= need_q)
    else $error("run count beyond request");
  a_find_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ffba_pkg::S_FIND && idx_q == LastIdx && !found_d) |=>
    (state_q == ffba_pkg::S_DONE && !rstat_q))
    else $error("failed search did not report failure");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import ffba_pkg::*;

  localparam int unsigned NBLK = HeapBytesDef / BlockBytesDef;
  localparam int unsigned CYCLE_LIMIT = 20000000;

  typedef struct packed {
    logic [1:0]  op;
    logic [17:0] bytes;
    logic [31:0] addr;
  } heap_req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] addr;
    logic [10:0] fb;
    logic [10:0] ub;
    logic [9:0]  fr;
    logic [9:0]  ur;
  } heap_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [31:0] cfg_heap_base_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] operation_i = '0;
  logic [17:0] request_bytes_i = '0;
  logic [31:0] release_address_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic status_o;
  logic [31:0] alloc_address_o;
  logic [10:0] free_block_total_o, used_block_total_o;
  logic [9:0] free_region_total_o, used_region_total_o;

  first_fit_block_allocator uut (.*);

  heap_req_t pending_reqs[$];
  heap_rsp_t expected_rsps[$];
  logic        used_map[NBLK];
  logic [10:0] run_len[NBLK];
  logic [31:0] heap_base = '0;
  logic [31:0] live_addrs[$];
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  logic hold_off = 1'b0;
  logic in_took = 1'b0;
  bit stall_mode = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  function automatic heap_rsp_t heap_predict(heap_req_t r);
    heap_rsp_t o;
    int need, start, len, idx;
    logic [32:0] off;
    logic prev;
    o = '0;
    o.status = 1'b1;
    if (r.op == OP_ALLOC) begin
      need = (int'(r.bytes) + BlockBytesDef - 1) / BlockBytesDef;
      o.status = 1'b0;
      if (need == 0) begin
        o.status = 1'b1;
        o.addr = heap_base;
      end else if (need <= NBLK) begin
        start = 0;
        len = 0;
        for (int i = 0; i < NBLK; i++) begin
          if (used_map[i]) begin
            len = 0;
            start = i + 1;
          end else begin
            len++;
            if (len == need) begin
              for (int k = 0; k < need; k++) begin
                used_map[start + k] = 1'b1;
                run_len[start + k] = '0;
              end
              run_len[start] = 11'(need);
              o.status = 1'b1;
              o.addr = heap_base + 32'(start * BlockBytesDef);
              break;
            end
          end
        end
      end
    end else if (r.op == OP_FREE) begin
      off = {1'b0, r.addr} - {1'b0, heap_base};
      if (r.addr != 0 && r.addr >= heap_base && off < HeapBytesDef) begin
        idx = int'(off) / BlockBytesDef;
        len = run_len[idx];
        for (int k = 0; k < len && idx + k < NBLK; k++) begin
          used_map[idx + k] = 1'b0;
          run_len[idx + k] = '0;
        end
      end
    end else if (r.op == OP_STATS) begin
      for (int i = 0; i < NBLK; i++) begin
        if (used_map[i]) begin
          o.ub++;
          if (i == 0 || !prev) o.ur++;
        end else begin
          o.fb++;
          if (i == 0 || prev) o.fr++;
        end
        prev = used_map[i];
      end
    end
    return o;
  endfunction

  task automatic queue_req(logic [1:0] op, logic [17:0] b, logic [31:0] a);
    heap_req_t r;
    r.op = op;
    r.bytes = b;
    r.addr = a;
    pending_reqs.push_back(r);
  endtask

  task automatic drain_and_wait();
    while (pending_reqs.size() != 0 || in_valid_i || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (2 * NBLK + 20) @(posedge clk_i);
  endtask

  task automatic write_base(logic [31:0] v);
    @(negedge clk_i);
    cfg_heap_base_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    heap_base = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int sel;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        if ($urandom_range(0, 9) == 0) queue_req(OP_ALLOC, 18'($urandom), '0);
        else queue_req(OP_ALLOC, 18'($urandom_range(0, 4096)), '0);
        live_addrs.push_back(heap_base + 32'($urandom_range(0, NBLK - 1) * BlockBytesDef));
      end else if (sel < 75) begin
        if (live_addrs.size() != 0 && $urandom_range(0, 3) != 0) begin
          a = live_addrs[$urandom_range(0, live_addrs.size() - 1)]
              + 32'($urandom_range(0, BlockBytesDef - 1));
        end else begin
          a = $urandom;
        end
        queue_req(OP_FREE, 18'($urandom), a);
      end else if (sel < 95) begin
        queue_req(OP_STATS, 18'($urandom), $urandom);
      end else begin
        queue_req(2'd3, 18'($urandom), $urandom);
      end
      if (pending_reqs.size() > 40) wait (pending_reqs.size() < 10);
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (!hold_off && pending_reqs.size() != 0) begin
          operation_i <= pending_reqs[0].op;
          request_bytes_i <= pending_reqs[0].bytes;
          release_address_i <= pending_reqs[0].addr;
          in_valid_i <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2000);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if ($urandom_range(0, 199) == 0) stall_mode = ~stall_mode;
      out_ready_i <= stall_mode ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    heap_rsp_t got, exp;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
    in_took = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_rsps.push_back(heap_predict(pending_reqs.pop_front()));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {status_o, alloc_address_o, free_block_total_o, used_block_total_o,
             free_region_total_o, used_region_total_o};
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        exp = expected_rsps.pop_front();
        if (got !== exp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%b ad=%h fb=%0d ub=%0d fr=%0d ur=%0d got st=%b ad=%h fb=%0d ub=%0d fr=%0d ur=%0d",
                     exp.status, exp.addr, exp.fb, exp.ub, exp.fr, exp.ur,
                     got.status, got.addr, got.fb, got.ub, got.fr, got.ur);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NBLK; i++) begin
      used_map[i] = 1'b0;
      run_len[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    write_base(32'h0000_1000);
    queue_req(OP_STATS, '0, '0);
    queue_req(OP_ALLOC, '0, '0);
    queue_req(OP_ALLOC, 18'd1, '0);
    queue_req(OP_ALLOC, 18'd128, '0);
    queue_req(OP_ALLOC, 18'd129, '0);
    queue_req(OP_ALLOC, 18'h3FFFF, '0);
    queue_req(OP_ALLOC, 18'd131073, '0);
    queue_req(OP_STATS, 18'h3FFFF, 32'hFFFF_FFFF);
    queue_req(OP_FREE, '0, '0);
    queue_req(OP_FREE, '0, 32'h0000_0FFF);
    queue_req(OP_FREE, '0, 32'h0002_1000);
    queue_req(OP_FREE, '0, 32'hFFFF_FFFF);
    queue_req(OP_FREE, '0, 32'h0000_1100);
    queue_req(OP_FREE, '0, 32'h0000_10FF);
    queue_req(OP_FREE, '0, 32'h0000_1000);
    queue_req(OP_STATS, '0, '0);
    queue_req(OP_ALLOC, 18'd131072, '0);
    queue_req(OP_ALLOC, 18'd1, '0);
    queue_req(OP_STATS, '0, '0);
    queue_req(OP_FREE, '0, 32'h0000_1000);
    queue_req(2'd3, 18'h3FFFF, 32'hFFFF_FFFF);
    queue_req(OP_STATS, '0, '0);
    drain_and_wait();
    write_base(32'hFFFF_FF80);
    random_phase(150);
    hold_off = 1'b1;
    wait (expected_rsps.size() == 0 && !in_valid_i);
    repeat (2 * NBLK + 20) @(posedge clk_i);
    hold_off = 1'b0;
    random_phase(130);
    drain_and_wait();
    write_base(32'h0000_0000);
    random_phase(150);
    drain_and_wait();
    write_base($urandom);
    random_phase(150);
    drain_and_wait();
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/ffba_pkg.sv
rtl/core/ffba_cell.sv
rtl/core/first_fit_block_allocator.sv
tb/testbench.sv
